FILE: src/jsc_pkg.sv
package jsc_pkg;

    // Deepest nesting below the root object
    localparam int MAX_DEPTH   = 16;
    // Container marks kept: root plus MAX_DEPTH levels
    localparam int STACK_DEPTH = MAX_DEPTH + 1;
    // Open container count runs 0..STACK_DEPTH
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    // Byte codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Write into the container mark stack
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic             is_obj;
    } t_push;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

endpackage

FILE: src/jsc_kind_stack.sv
module jsc_kind_stack (
    input  logic                       i_clk,
    input  jsc_pkg::t_push             i_push,
    input  logic [jsc_pkg::IDX_W-1:0]  i_rd_idx,
    output logic                       o_is_obj
);

    // One mark per open container: 1 = object, 0 = array
    logic r_kind [jsc_pkg::STACK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_push.we) begin
            r_kind[i_push.idx] <= i_push.is_obj;
        end
    end

    assign o_is_obj = r_kind[i_rd_idx];

endmodule

FILE: src/jsc_fsm.sv
module jsc_fsm (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [7:0]                 i_byte,
    input  logic                       i_eom,
    input  logic                       i_top_is_obj,
    output logic [jsc_pkg::IDX_W-1:0]  o_top_idx,
    output jsc_pkg::t_push             o_push,
    output logic                       o_accepted
);

    typedef enum logic [3:0] {
        PH_ROOT, PH_OBJ_FIRST, PH_ARR_FIRST, PH_KEY_NEXT, PH_KEY_BODY,
        PH_KEY_ESC, PH_KEY_HEX, PH_COLON, PH_VALUE, PH_VAL_BODY,
        PH_VAL_ESC, PH_VAL_HEX, PH_PRIM, PH_AFTER, PH_DONE
    } t_phase;

    localparam int CW = jsc_pkg::CNT_W;

    t_phase          r_phase, n_phase;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [2:0]      r_hex, n_hex;
    logic            r_fail, n_fail;

    logic [7:0]      c;
    logic            ws, cnt_nz, top_obj, push_ok;
    logic [CW-1:0]   cnt_m1, cnt_p1, pop_cnt;
    t_phase          pop_phase;
    logic [2:0]      hex_dec;

    // after-value helper
    t_phase          av_phase;
    logic [CW-1:0]   av_cnt;
    logic            av_fail;
    // start-value helper
    t_phase          sv_phase;
    logic [CW-1:0]   sv_cnt;
    logic            sv_fail, sv_we;

    assign c        = i_byte;
    assign ws       = jsc_pkg::is_ws(c);
    assign cnt_nz   = (r_cnt != '0);
    assign cnt_m1   = r_cnt - CW'(1);
    assign cnt_p1   = r_cnt + CW'(1);
    assign push_ok  = (r_cnt < CW'(jsc_pkg::STACK_DEPTH));
    assign top_obj  = cnt_nz && (r_cnt <= CW'(jsc_pkg::STACK_DEPTH)) && i_top_is_obj;
    assign pop_cnt  = cnt_nz ? cnt_m1 : r_cnt;
    assign pop_phase = (pop_cnt == '0) ? PH_DONE : PH_AFTER;
    assign hex_dec  = (r_hex != 3'd0) ? r_hex - 3'd1 : r_hex;

    assign o_top_idx = cnt_m1[jsc_pkg::IDX_W-1:0];

    // Byte after a complete value: separator, close or whitespace
    always_comb begin
        av_phase = r_phase;
        av_cnt   = r_cnt;
        av_fail  = 1'b0;
        if (!ws) begin
            if (c == jsc_pkg::CH_COMMA) begin
                av_phase = top_obj ? PH_KEY_NEXT : PH_VALUE;
            end else if ((c == jsc_pkg::CH_RBRACE && top_obj) ||
                         (c == jsc_pkg::CH_RBRACK && !top_obj && cnt_nz)) begin
                av_cnt   = pop_cnt;
                av_phase = pop_phase;
            end else begin
                av_fail = 1'b1;
            end
        end
    end

    // First byte of a value
    always_comb begin
        sv_phase = r_phase;
        sv_cnt   = r_cnt;
        sv_fail  = 1'b0;
        sv_we    = 1'b0;
        if (r_cnt > CW'(jsc_pkg::MAX_DEPTH)) begin
            sv_fail = 1'b1;
        end else if (c == jsc_pkg::CH_QUOTE) begin
            sv_phase = PH_VAL_BODY;
        end else if (c == jsc_pkg::CH_LBRACE || c == jsc_pkg::CH_LBRACK) begin
            if (!push_ok) begin
                sv_fail = 1'b1;
            end else begin
                sv_we    = 1'b1;
                sv_cnt   = cnt_p1;
                sv_phase = (c == jsc_pkg::CH_LBRACE) ? PH_OBJ_FIRST : PH_ARR_FIRST;
            end
        end else if (c == jsc_pkg::CH_COMMA || c == jsc_pkg::CH_RBRACE ||
                     c == jsc_pkg::CH_RBRACK) begin
            sv_fail = 1'b1;
        end else begin
            sv_phase = PH_PRIM;
        end
    end

    // Per-byte transition
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_hex   = r_hex;
        n_fail  = r_fail;
        o_push.we     = 1'b0;
        o_push.idx    = r_cnt[jsc_pkg::IDX_W-1:0];
        o_push.is_obj = (c == jsc_pkg::CH_LBRACE);
        if (i_go && !r_fail) begin
            unique case (r_phase) inside
                PH_ROOT: begin
                    if (!ws) begin
                        if (c == jsc_pkg::CH_LBRACE && push_ok) begin
                            o_push.we = 1'b1;
                            n_cnt     = cnt_p1;
                            n_phase   = PH_OBJ_FIRST;
                        end else begin
                            n_fail = 1'b1;
                        end
                    end
                end
                PH_OBJ_FIRST: begin
                    if (!ws) begin
                        if (c == jsc_pkg::CH_RBRACE) begin
                            n_cnt   = pop_cnt;
                            n_phase = pop_phase;
                        end else if (c == jsc_pkg::CH_QUOTE) begin
                            n_phase = PH_KEY_BODY;
                        end else begin
                            n_fail = 1'b1;
                        end
                    end
                end
                PH_ARR_FIRST: begin
                    if (!ws) begin
                        if (c == jsc_pkg::CH_RBRACK) begin
                            n_cnt   = pop_cnt;
                            n_phase = pop_phase;
                        end else begin
                            n_phase   = sv_phase;
                            n_cnt     = sv_cnt;
                            n_fail    = sv_fail;
                            o_push.we = sv_we;
                        end
                    end
                end
                PH_KEY_NEXT: begin
                    if (!ws) begin
                        if (c == jsc_pkg::CH_QUOTE) n_phase = PH_KEY_BODY;
                        else n_fail = 1'b1;
                    end
                end
                PH_KEY_BODY, PH_VAL_BODY: begin
                    if (c < jsc_pkg::CH_SPACE) begin
                        n_fail = 1'b1;
                    end else if (c == jsc_pkg::CH_BSLASH) begin
                        n_phase = (r_phase == PH_KEY_BODY) ? PH_KEY_ESC : PH_VAL_ESC;
                    end else if (c == jsc_pkg::CH_QUOTE) begin
                        n_phase = (r_phase == PH_KEY_BODY) ? PH_COLON : PH_AFTER;
                    end
                end
                PH_KEY_ESC, PH_VAL_ESC: begin
                    if (c == jsc_pkg::CH_LOWER_U) begin
                        n_hex   = 3'd4;
                        n_phase = (r_phase == PH_KEY_ESC) ? PH_KEY_HEX : PH_VAL_HEX;
                    end else begin
                        n_phase = (r_phase == PH_KEY_ESC) ? PH_KEY_BODY : PH_VAL_BODY;
                    end
                end
                PH_KEY_HEX, PH_VAL_HEX: begin
                    if (!jsc_pkg::is_hex(c)) begin
                        n_fail = 1'b1;
                    end else begin
                        n_hex = hex_dec;
                        if (hex_dec == 3'd0) begin
                            n_phase = (r_phase == PH_KEY_HEX) ? PH_KEY_BODY : PH_VAL_BODY;
                        end
                    end
                end
                PH_COLON: begin
                    if (!ws) begin
                        if (c == jsc_pkg::CH_COLON) n_phase = PH_VALUE;
                        else n_fail = 1'b1;
                    end
                end
                PH_VALUE: begin
                    if (!ws) begin
                        n_phase   = sv_phase;
                        n_cnt     = sv_cnt;
                        n_fail    = sv_fail;
                        o_push.we = sv_we;
                    end
                end
                PH_PRIM: begin
                    // primitive ends at whitespace, comma or a close
                    if (ws || c == jsc_pkg::CH_COMMA || c == jsc_pkg::CH_RBRACE ||
                        c == jsc_pkg::CH_RBRACK) begin
                        n_phase = ws ? PH_AFTER : av_phase;
                        n_cnt   = av_cnt;
                        n_fail  = av_fail;
                    end
                end
                PH_AFTER: begin
                    n_phase = av_phase;
                    n_cnt   = av_cnt;
                    n_fail  = av_fail;
                end
                PH_DONE: begin
                    if (!ws) n_fail = 1'b1;
                end
                default: begin
                    n_fail = 1'b1;
                end
            endcase
        end

        o_accepted = !n_fail && (n_phase == PH_DONE);

        // final byte: clear for next message
        if (i_go && i_eom) begin
            n_phase = PH_ROOT;
            n_cnt   = '0;
            n_hex   = 3'd0;
            n_fail  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ROOT;
            r_cnt   <= '0;
            r_hex   <= 3'd0;
            r_fail  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_hex   <= n_hex;
            r_fail  <= n_fail;
        end
    end

endmodule

FILE: src/json_syntax_checker_unit.sv
// Streaming JSON object checker.
// Input channel: one message byte per word on i_data_byte, with
// i_end_of_message marking the final byte; a word moves when i_valid is high
// and o_stall is low. Output channel: one word per message, o_accepted = 1
// when the message was a single well-formed object with only surrounding
// whitespace; it moves when o_valid is high and i_stall is low.
// The result of a final byte passes the input register, then the result
// register. Throughput: one byte per cycle unless a final byte waits behind
// a held result; each byte passes the input register and one parser transition.
// Nesting depth is limited by the container mark stack (MAX_DEPTH levels
// below the root object).
// Reset (synchronous, active low) empties both registers and returns the
// parser to expect the root open brace; the mark stack is not cleared.
// When the receiver stalls, the result is held; bytes that produce no
// result keep flowing, and o_stall rises only when a final byte is waiting
// behind a held result.
module json_syntax_checker_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_accepted
);

    logic                      r_s1_valid;
    logic [7:0]                r_s1_byte;
    logic                      r_s1_eom;
    logic                      r_out_valid;
    logic                      r_out_acc;

    logic                      out_free, s1_go, in_take;
    logic                      fsm_acc, top_is_obj;
    logic [jsc_pkg::IDX_W-1:0] top_idx;
    jsc_pkg::t_push            push;

    // Handshake: a final byte waits only while a result is held
    assign out_free = !r_out_valid || !i_stall;
    assign s1_go    = r_s1_valid && (!r_s1_eom || out_free);
    assign in_take  = i_valid && (!r_s1_valid || s1_go);
    assign o_stall  = r_s1_valid && !s1_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_data_byte;
            r_s1_eom  <= i_end_of_message;
        end
    end

    jsc_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (s1_go),
        .i_byte       (r_s1_byte),
        .i_eom        (r_s1_eom),
        .i_top_is_obj (top_is_obj),
        .o_top_idx    (top_idx),
        .o_push       (push),
        .o_accepted   (fsm_acc)
    );

    jsc_kind_stack u_stack (
        .i_clk    (i_clk),
        .i_push   (push),
        .i_rd_idx (top_idx),
        .o_is_obj (top_is_obj)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_eom) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_eom) begin
            r_out_acc <= fsm_acc;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_accepted = r_out_acc;

endmodule

FILE: src/jsc_checker.sv
module jsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_data_byte,
    input logic       i_end_of_message,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_accepted
);

    // No result is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // Input backs up only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // A new result follows a final byte taken at the input
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && i_end_of_message, 2))
        else $error("result without a final byte");

    // Held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_accepted)))
        else $error("stalled result changed");

endmodule

bind json_syntax_checker_unit jsc_checker u_jsc_checker (.*);

FILE: test/json_syntax_checker_monitor.sv
`timescale 1ns / 100ps

// Watches both channels of the JSON checker, runs its own parser on every
// accepted word and compares each result word with the oldest verdict.
module json_syntax_checker_monitor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    input  logic       o_valid,
    input  logic       i_stall,
    input  logic       o_accepted,
    output int         o_fail_count,
    output int         o_pending
);
    import jsc_pkg::*;

    typedef enum logic [3:0] {
        AT_ROOT,
        OBJ_OPEN,
        ARR_OPEN,
        KEY_WAIT,
        KEY_TEXT,
        KEY_ESCAPE,
        KEY_UNICODE,
        COLON_WAIT,
        VALUE_WAIT,
        STR_TEXT,
        STR_ESCAPE,
        STR_UNICODE,
        BARE_TEXT,
        VALUE_DONE,
        ROOT_CLOSED
    } parse_phase_e;

    // Parser state
    parse_phase_e phase;
    logic         mark_is_obj [STACK_DEPTH];
    int unsigned  depth;
    int unsigned  hex_left;
    logic         broken;

    // One verdict per message whose final word went in
    logic         verdicts [$];
    logic         want_accept;

    function automatic logic is_blank(input logic [7:0] c);
        case (c)
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, CH_SPACE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Case folding maps A-F onto a-f; nothing else lands there
    function automatic logic is_hex_digit(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        return (c >= "0" && c <= "9") || (folded >= "a" && folded <= "f");
    endfunction

    function automatic void clear_parser();
        phase    = AT_ROOT;
        depth    = 0;
        hex_left = 0;
        broken   = 1'b0;
    endfunction

    function automatic void open_container(input logic is_obj);
        if (depth >= STACK_DEPTH) begin
            broken = 1'b1;
        end else begin
            mark_is_obj[depth] = is_obj;
            depth++;
            phase = is_obj ? OBJ_OPEN : ARR_OPEN;
        end
    endfunction

    function automatic void close_container();
        if (depth != 0) begin
            depth--;
        end
        phase = (depth == 0) ? ROOT_CLOSED : VALUE_DONE;
    endfunction

    function automatic logic inner_is_obj();
        return depth != 0 && mark_is_obj[depth - 1];
    endfunction

    // First byte of a value; nothing may open below the depth limit
    function automatic void begin_value(input logic [7:0] c);
        if (depth > MAX_DEPTH) begin
            broken = 1'b1;
        end else if (c == CH_QUOTE) begin
            phase = STR_TEXT;
        end else if (c == CH_LBRACE) begin
            open_container(1'b1);
        end else if (c == CH_LBRACK) begin
            open_container(1'b0);
        end else if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK) begin
            broken = 1'b1;
        end else begin
            phase = BARE_TEXT;
        end
    endfunction

    function automatic void after_value(input logic [7:0] c);
        if (!is_blank(c)) begin
            if (c == CH_COMMA) begin
                phase = inner_is_obj() ? KEY_WAIT : VALUE_WAIT;
            end else if ((c == CH_RBRACE && inner_is_obj()) ||
                         (c == CH_RBRACK && !inner_is_obj() && depth != 0)) begin
                close_container();
            end else begin
                broken = 1'b1;
            end
        end
    endfunction

    function automatic void string_char(input logic [7:0] c, input logic key);
        if (c < CH_SPACE) begin
            broken = 1'b1;
        end else if (c == CH_BSLASH) begin
            phase = key ? KEY_ESCAPE : STR_ESCAPE;
        end else if (c == CH_QUOTE) begin
            phase = key ? COLON_WAIT : VALUE_DONE;
        end
    endfunction

    function automatic void escape_char(input logic [7:0] c, input logic key);
        if (c == CH_LOWER_U) begin
            hex_left = 4;
            phase    = key ? KEY_UNICODE : STR_UNICODE;
        end else begin
            phase = key ? KEY_TEXT : STR_TEXT;
        end
    endfunction

    function automatic void unicode_char(input logic [7:0] c, input logic key);
        if (!is_hex_digit(c)) begin
            broken = 1'b1;
        end else begin
            if (hex_left != 0) begin
                hex_left--;
            end
            if (hex_left == 0) begin
                phase = key ? KEY_TEXT : STR_TEXT;
            end
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        case (phase)
            AT_ROOT: begin
                if (!is_blank(c)) begin
                    if (c == CH_LBRACE) open_container(1'b1);
                    else broken = 1'b1;
                end
            end
            OBJ_OPEN: begin
                if (!is_blank(c)) begin
                    if (c == CH_RBRACE) close_container();
                    else if (c == CH_QUOTE) phase = KEY_TEXT;
                    else broken = 1'b1;
                end
            end
            ARR_OPEN: begin
                if (!is_blank(c)) begin
                    if (c == CH_RBRACK) close_container();
                    else begin_value(c);
                end
            end
            KEY_WAIT: begin
                if (!is_blank(c)) begin
                    if (c == CH_QUOTE) phase = KEY_TEXT;
                    else broken = 1'b1;
                end
            end
            KEY_TEXT:    string_char(c, 1'b1);
            KEY_ESCAPE:  escape_char(c, 1'b1);
            KEY_UNICODE: unicode_char(c, 1'b1);
            COLON_WAIT: begin
                if (!is_blank(c)) begin
                    if (c == CH_COLON) phase = VALUE_WAIT;
                    else broken = 1'b1;
                end
            end
            VALUE_WAIT: begin
                if (!is_blank(c)) begin_value(c);
            end
            STR_TEXT:    string_char(c, 1'b0);
            STR_ESCAPE:  escape_char(c, 1'b0);
            STR_UNICODE: unicode_char(c, 1'b0);
            // a bare value runs until a blank or a separator
            BARE_TEXT: begin
                if (is_blank(c) || c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK) begin
                    phase = VALUE_DONE;
                    after_value(c);
                end
            end
            VALUE_DONE: after_value(c);
            ROOT_CLOSED: begin
                if (!is_blank(c)) broken = 1'b1;
            end
            default: broken = 1'b1;
        endcase
    endfunction

    // Result side first: a result word never belongs to the word going in
    // at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            verdicts.delete();
            o_fail_count = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (verdicts.size() == 0) begin
                    $error("accepted: expected no word, actual %0b", o_accepted);
                    o_fail_count++;
                end else begin
                    want_accept = verdicts.pop_front();
                    if (o_accepted !== want_accept) begin
                        $error("accepted: expected %0b, actual %0b", want_accept, o_accepted);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                // errors are sticky: later bytes are skipped
                if (!broken) parse_byte(i_data_byte);
                if (i_end_of_message) begin
                    verdicts.push_back(!broken && phase == ROOT_CLOSED);
                    clear_parser();
                end
            end
        end
        o_pending = verdicts.size();
    end

endmodule

FILE: test/json_syntax_checker_unit_tb.sv
`timescale 1ns / 100ps

// Drives messages into the JSON checker: a few hand-made ones, then mostly
// well-formed objects with random content, some damaged, some pure noise.
module json_syntax_checker_unit_tb;
    import jsc_pkg::*;

    localparam int ITEM_TARGET    = 1450;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_e;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_data_byte;
    logic       i_end_of_message;
    logic       o_valid;
    logic       i_stall;
    logic       o_accepted;

    int          fail_count;
    int          pending;
    logic        hold_req = 1'b0;
    int unsigned sent_words;
    int unsigned burst_left;
    int unsigned quiet_cycles = 0;
    logic [7:0]  msg [$];
    string       hex_chars  = "0123456789abcdefABCDEF";
    string       bare_chars = "0123456789-+.eEtrufalsn";

    json_syntax_checker_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_accepted       (o_accepted)
    );

    json_syntax_checker_monitor verdict_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_accepted       (o_accepted),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: ends the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: stall pattern is picked anew at random; a hold request
    // keeps it stalled for a long stretch, once
    initial begin : receiver
        stall_mode_e mode;
        int unsigned span;
        logic        hold_done;
        i_stall   = 1'b0;
        hold_done = 1'b0;
        forever begin
            mode = stall_mode_e'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_req && !hold_done) begin
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_stall <= ~i_stall;
                endcase
            end
        end
    end

    function automatic logic [7:0] random_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 5))
            0: return 8'h09;
            1: return 8'h0A;
            2: return 8'h0B;
            3: return 8'h0C;
            4: return 8'h0D;
            default: return CH_SPACE;
        endcase
    endfunction

    // Sender: bursts of words with random gaps in between
    task automatic send_word(input logic [7:0] b, input logic last);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_end_of_message <= last;
        do @(posedge i_clk); while (o_stall);
        sent_words++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_word(s[k], k == s.len() - 1);
        end
    endtask

    task automatic send_message();
        for (int k = 0; k < msg.size(); k++) begin
            send_word(msg[k], k == msg.size() - 1);
        end
    endtask

    // Idle the sender until every verdict has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    task automatic maybe_blank();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) msg.push_back(blank_byte());
        end
    endtask

    task automatic put_hex4();
        repeat (4) msg.push_back(hex_chars[$urandom_range(0, 21)]);
    endtask

    // Quoted string with plain bytes, escapes of any byte and unicode escapes
    task automatic put_string();
        logic [7:0] b;
        msg.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 9))
                0: begin
                    b = random_byte();
                    msg.push_back(CH_BSLASH);
                    msg.push_back(b);
                    if (b == CH_LOWER_U) put_hex4();
                end
                1: begin
                    msg.push_back(CH_BSLASH);
                    msg.push_back(CH_LOWER_U);
                    put_hex4();
                end
                default: begin
                    b = 8'($urandom_range(32, 255));
                    if (b == CH_QUOTE || b == CH_BSLASH) b = "a";
                    msg.push_back(b);
                end
            endcase
        end
        msg.push_back(CH_QUOTE);
    endtask

    task automatic put_bare();
        logic [7:0] b;
        repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 5) == 0) begin
                b = random_byte();
                if (b <= CH_SPACE || b == CH_COMMA || b == CH_RBRACE || b == CH_RBRACK) b = "7";
            end else begin
                b = bare_chars[$urandom_range(0, bare_chars.len() - 1)];
            end
            msg.push_back(b);
        end
    endtask

    // Well-formed object; a nonzero dive first nests until that many containers, root included, are open
    task automatic build_object(input int unsigned dive);
        logic        kind [0:STACK_DEPTH+3];
        int unsigned open_cnt;
        int unsigned steps;
        int unsigned budget;
        logic        first;
        logic        diving;
        logic        nest;
        maybe_blank();
        msg.push_back(CH_LBRACE);
        kind[0]  = 1'b1;
        open_cnt = 1;
        first    = 1'b1;
        steps    = 0;
        budget   = $urandom_range(2, 14) + dive;
        diving   = (dive != 0);
        while (open_cnt > 0) begin
            if (diving && open_cnt >= dive) diving = 1'b0;
            maybe_blank();
            if (!diving && (steps >= budget || $urandom_range(0, 2) == 0)) begin
                msg.push_back(kind[open_cnt-1] ? CH_RBRACE : CH_RBRACK);
                open_cnt--;
                first = 1'b0;
            end else begin
                if (!first) msg.push_back(CH_COMMA);
                if (kind[open_cnt-1]) begin
                    put_string();
                    maybe_blank();
                    msg.push_back(CH_COLON);
                    maybe_blank();
                end
                nest = diving || (open_cnt < 4 && $urandom_range(0, 3) == 0);
                if (nest) begin
                    kind[open_cnt] = 1'($urandom_range(0, 1));
                    msg.push_back(kind[open_cnt] ? CH_LBRACE : CH_LBRACK);
                    open_cnt++;
                    first = 1'b1;
                end else begin
                    if ($urandom_range(0, 1) == 0) put_string();
                    else put_bare();
                    first = 1'b0;
                end
            end
            steps++;
        end
        maybe_blank();
    endtask

    // Damage a message: overwrite, drop, insert, cut short or add a trailing comma
    task automatic mutate();
        int unsigned at;
        at = $urandom_range(0, msg.size() - 1);
        case ($urandom_range(0, 4))
            0: msg[at] = random_byte();
            1: begin
                if (msg.size() > 1) msg.delete(at);
            end
            2: msg.insert(at, random_byte());
            3: begin
                while (msg.size() > at + 1) msg.pop_back();
            end
            default: begin
                while (at < msg.size() && msg[at] != CH_RBRACE && msg[at] != CH_RBRACK) at++;
                if (at < msg.size()) msg.insert(at, CH_COMMA);
            end
        endcase
    endtask

    initial begin : stimulus
        int unsigned dive;
        logic        held;
        logic        drained;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_data_byte      = 8'h00;
        i_end_of_message = 1'b0;
        sent_words       = 0;
        burst_left       = 0;
        held             = 1'b0;
        drained          = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest object, top byte alone, sticky error,
        // control byte in a key, unicode escape with an empty array
        send_text("{}");
        send_word(8'hFF, 1'b1);
        send_text("x{}");
        send_word(CH_LBRACE, 1'b0);
        send_word(CH_QUOTE, 1'b0);
        send_word(8'h00, 1'b1);
        send_text("{\"\\u0aF9\":[]}");

        // Random messages
        while (sent_words < ITEM_TARGET) begin
            msg.delete();
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 8)) msg.push_back(random_byte());
            end else begin
                dive = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_DEPTH, MAX_DEPTH + 2) : 0;
                build_object(dive);
                if ($urandom_range(0, 3) == 0) mutate();
            end
            // long receiver hold while words keep coming
            if (!held && sent_words > 400) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!drained && sent_words > 900) begin
                drain();
                drained = 1'b1;
            end
            send_message();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
